/* rtl/core/hashed_result_cache_macros.svh */
// Assertion macros for the result cache RTL.
`ifndef HASHED_RESULT_CACHE_MACROS_SVH
`define HASHED_RESULT_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("result cache check failed");

// Next-cycle implication, checked outside reset.
`define HRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("result cache check failed");

`endif

/* rtl/core/hrc_pkg.sv */
// Types, constants and the slot mixing function of the result cache.
package hrc_pkg;

    localparam int ENTRIES_DEFAULT = 4096;
    localparam int KEY_W           = 64;
    localparam int TAG_W           = 16;
    localparam int VALUE_W         = 16;

    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [KEY_W-1:0]          lookup_key;
        logic [TAG_W-1:0]          tag_word;
        logic signed [VALUE_W-1:0] store_value;
    } t_in_word;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] found_value;
    } t_out_word;

    typedef struct packed {
        logic                      vld;
        logic [KEY_W-1:0]          key;
        logic [TAG_W-1:0]          tag;
        logic signed [VALUE_W-1:0] value;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    function automatic logic [KEY_W-1:0] mix(input logic [KEY_W-1:0] key,
                                             input logic [TAG_W-1:0] tag);
        logic [KEY_W-1:0] wide_tag;
        wide_tag = {{(KEY_W-TAG_W){1'b0}}, tag};
        return key ^ (key >> 17) ^ (key << 13) ^ (wide_tag << 1);
    endfunction

endpackage

/* rtl/core/hrc_ram.sv */
// Generic single-port RAM with a registered read port.
module hrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/hrc_slot.sv */
// Slot index unit: mixes key and tag and reduces the mix modulo the entry count.
module hrc_slot #(
    parameter int ENTRIES = hrc_pkg::ENTRIES_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  hrc_pkg::t_in_word          i_word,
    output logic                       o_valid,
    input  logic                       i_stall,
    output hrc_pkg::t_in_word          o_word,
    output logic [$clog2(ENTRIES)-1:0] o_slot
);

    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CHUNK_W = 8;

    logic [hrc_pkg::KEY_W-1:0] mix_val;

    // Weight of one byte of the mix, reduced modulo the entry count.
    function automatic logic [SLOT_W-1:0] chunk_weight(input int idx);
        longint w;
        w = 1;
        for (int k = 0; k < idx; k++) begin
            w = (w << CHUNK_W) % ENTRIES;
        end
        return SLOT_W'(w);
    endfunction

    assign mix_val = hrc_pkg::mix(i_word.lookup_key, i_word.tag_word);

    if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
        assign o_valid = i_valid;
        assign o_stall = i_stall;
        assign o_word  = i_word;
        assign o_slot  = mix_val[SLOT_W-1:0];
    end else begin : g_fold
        localparam int     CHUNKS = hrc_pkg::KEY_W / CHUNK_W;
        localparam int     SUM_W  = SLOT_W + CHUNK_W + $clog2(CHUNKS);
        localparam int     RCP_W  = SUM_W - SLOT_W + 1;
        localparam longint RCP    = (longint'(1) << SUM_W) / ENTRIES;

        logic [2:0]                r_stage;
        logic                      r_done;
        logic [hrc_pkg::KEY_W-1:0] r_m;
        logic [SUM_W-1:0]          r_sum;
        logic [RCP_W-1:0]          r_q;
        logic [SLOT_W-1:0]         r_rem;
        hrc_pkg::t_in_word         r_word;
        logic                      busy;
        logic                      accept;
        logic [SUM_W-1:0]          fold_sum;
        logic [SUM_W+RCP_W-1:0]    quot_prod;
        logic [SUM_W-1:0]          rem_wide;
        logic [SUM_W-1:0]          rem_fix;

        always_comb begin
            fold_sum = '0;
            for (int i = 0; i < CHUNKS; i++) begin
                fold_sum = fold_sum + SUM_W'(r_m[i*CHUNK_W +: CHUNK_W])
                                      * SUM_W'(chunk_weight(i));
            end
        end

        assign quot_prod = (SUM_W+RCP_W)'(r_sum) * (SUM_W+RCP_W)'(RCP);
        assign rem_wide  = r_sum - SUM_W'(r_q) * SUM_W'(ENTRIES);
        assign rem_fix   = (rem_wide >= SUM_W'(ENTRIES)) ? rem_wide - SUM_W'(ENTRIES)
                                                         : rem_wide;

        assign busy   = |r_stage;
        assign accept = i_valid && !busy && !r_done;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stage <= '0;
                r_done  <= 1'b0;
            end else begin
                r_stage <= {r_stage[1:0], accept};
                if (accept) begin
                    r_word <= i_word;
                    r_m    <= mix_val;
                end
                if (r_stage[0]) begin
                    r_sum <= fold_sum;
                end
                if (r_stage[1]) begin
                    r_q <= quot_prod[SUM_W +: RCP_W];
                end
                if (r_stage[2]) begin
                    r_rem  <= rem_fix[SLOT_W-1:0];
                    r_done <= 1'b1;
                end else if (r_done && !i_stall) begin
                    r_done <= 1'b0;
                end
            end
        end

        assign o_valid = r_done;
        assign o_stall = busy | r_done;
        assign o_word  = r_word;
        assign o_slot  = r_rem;
    end

endmodule

/* rtl/core/hashed_result_cache.sv */
// Direct-mapped result cache: top level with slot memory, access stage and output register.
// A probe or store looks up one slot chosen by mixing the 64-bit key with the tag. With a
// power-of-two entry count the block takes one word per clock while the output is not stalled
// and no sweep runs; the result passes through the registered read of the single-port slot
// memory and then the output register. With any other entry count a remainder unit folds the
// mix with constant byte weights and a reciprocal multiply, registering the mix, the folded sum,
// the quotient and the remainder in turn; it takes no new word before the last is passed on. A
// clear sweeps every slot, one a cycle, and the block takes no word while the sweep runs; the
// same sweep runs after reset. Stored keys, tags and values need no reset; the sweep writes zero
// to every slot word, valid bit included.
module hashed_result_cache #(
    parameter int ENTRIES = hrc_pkg::ENTRIES_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hrc_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hrc_pkg::t_out_word o_out_data
);

`include "hashed_result_cache_macros.svh"

    localparam int SLOT_W = $clog2(ENTRIES);

    logic                      slot_valid;
    logic                      slot_stall;
    hrc_pkg::t_in_word         slot_word;
    logic [SLOT_W-1:0]         slot_idx;
    logic                      issue_req;

    logic                      r_sweeping;
    logic [SLOT_W-1:0]         r_sweep_addr;
    logic                      r_s1_vld;
    logic [1:0]                r_s1_cmd;
    logic [hrc_pkg::KEY_W-1:0] r_s1_key;
    logic [hrc_pkg::TAG_W-1:0] r_s1_tag;
    logic                      r_out_vld;
    hrc_pkg::t_out_word        r_out;
    hrc_pkg::t_out_word        n_out;

    logic                      out_load;
    logic                      s1_free;
    logic                      issue;
    logic                      ram_en;
    logic                      ram_we;
    logic [SLOT_W-1:0]         ram_addr;
    hrc_pkg::t_slot_word       ram_wdata;
    logic [hrc_pkg::SLOT_WORD_W-1:0] ram_rdata;
    hrc_pkg::t_slot_word       rd_word;

    hrc_slot #(
        .ENTRIES(ENTRIES)
    ) u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (slot_valid),
        .o_stall (slot_stall),
        .i_word  (i_in_data),
        .o_valid (issue_req),
        .i_stall (!(s1_free && !r_sweeping)),
        .o_word  (slot_word),
        .o_slot  (slot_idx)
    );

    assign slot_valid = i_in_valid && !r_sweeping;
    assign o_in_stall = r_sweeping || slot_stall;

    assign out_load = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign s1_free  = !r_s1_vld || out_load;
    assign issue    = issue_req && s1_free && !r_sweeping;

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = slot_idx;
        ram_wdata = '0;
        if (r_sweeping) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = r_sweep_addr;
        end else if (issue) begin
            unique case (slot_word.cmd)
                hrc_pkg::CMD_PROBE: begin
                    ram_en = 1'b1;
                end
                hrc_pkg::CMD_STORE: begin
                    ram_en          = 1'b1;
                    ram_we          = 1'b1;
                    ram_wdata.vld   = 1'b1;
                    ram_wdata.key   = slot_word.lookup_key;
                    ram_wdata.tag   = slot_word.tag_word;
                    ram_wdata.value = slot_word.store_value;
                end
                default: begin
                    ram_en = 1'b0;
                end
            endcase
        end
    end

    hrc_ram #(
        .WIDTH(hrc_pkg::SLOT_WORD_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_word = hrc_pkg::t_slot_word'(ram_rdata);

    always_comb begin
        n_out = '0;
        if (r_s1_cmd == hrc_pkg::CMD_PROBE && rd_word.vld && rd_word.key == r_s1_key
                && rd_word.tag == r_s1_tag) begin
            n_out.hit         = 1'b1;
            n_out.found_value = rd_word.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping   <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweeping) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            if (r_sweep_addr == SLOT_W'(ENTRIES - 1)) begin
                r_sweeping   <= 1'b0;
                r_sweep_addr <= '0;
            end
        end else if (issue && slot_word.cmd == hrc_pkg::CMD_CLEAR) begin
            r_sweeping <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (out_load) begin
                r_s1_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_cmd <= slot_word.cmd;
            r_s1_key <= slot_word.lookup_key;
            r_s1_tag <= slot_word.tag_word;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `HRC_ASSERT_NEXT(a_clear_starts_sweep, issue && slot_word.cmd == hrc_pkg::CMD_CLEAR, r_sweeping)
    `HRC_ASSERT_NEXT(a_issue_fills_stage, issue, r_s1_vld)
    `HRC_ASSERT_NOW(a_sweep_blocks_input, r_sweeping, o_in_stall && !issue)
    `HRC_ASSERT_NOW(a_miss_is_zero, o_out_valid && !o_out_data.hit, o_out_data.found_value == '0)

endmodule

/* sim/hashed_result_cache_checker.sv */
// Scoreboard for the result cache: keeps its own copy of the slots and checks every answer word.
`timescale 1ns / 1ps
module hashed_result_cache_checker #(
    parameter int ENTRIES = hrc_pkg::ENTRIES_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  hrc_pkg::t_in_word  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  hrc_pkg::t_out_word i_out_data,
    output int                 o_errors,
    output int                 o_awaiting
);

    logic [hrc_pkg::KEY_W-1:0]          cached_key   [ENTRIES];
    logic [hrc_pkg::TAG_W-1:0]          cached_tag   [ENTRIES];
    logic signed [hrc_pkg::VALUE_W-1:0] stored_value [ENTRIES];
    bit                                 cached_valid [ENTRIES];
    hrc_pkg::t_out_word                 awaited_answers [$];
    int                                 error_count = 0;

    function automatic int slot_for(input logic [hrc_pkg::KEY_W-1:0] key,
                                    input logic [hrc_pkg::TAG_W-1:0] tag);
        logic [hrc_pkg::KEY_W-1:0] folded;
        folded = key ^ (key >> 17) ^ (key << 13) ^ (hrc_pkg::KEY_W'(tag) << 1);
        return int'(folded % 64'(ENTRIES));
    endfunction

    task automatic apply_word(input hrc_pkg::t_in_word w, output hrc_pkg::t_out_word answer);
        int slot;
        answer = '0;
        slot   = slot_for(w.lookup_key, w.tag_word);
        case (w.cmd)
            hrc_pkg::CMD_PROBE: begin
                if (cached_valid[slot] && cached_key[slot] == w.lookup_key
                        && cached_tag[slot] == w.tag_word) begin
                    answer.hit         = 1'b1;
                    answer.found_value = stored_value[slot];
                end
            end
            hrc_pkg::CMD_STORE: begin
                cached_key[slot]   = w.lookup_key;
                cached_tag[slot]   = w.tag_word;
                stored_value[slot] = w.store_value;
                cached_valid[slot] = 1'b1;
            end
            hrc_pkg::CMD_CLEAR: begin
                foreach (cached_valid[i]) cached_valid[i] = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        hrc_pkg::t_out_word expected;
        if (!i_rst_n) begin
            foreach (cached_valid[i]) cached_valid[i] = 1'b0;
            awaited_answers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_answers.size() == 0) begin
                    $display("%0t: answer word hit=%0b value=%0d arrived with none expected",
                             $time, i_out_data.hit, i_out_data.found_value);
                    error_count++;
                end else begin
                    expected = awaited_answers.pop_front();
                    if (i_out_data.hit !== expected.hit) begin
                        $display("%0t: hit expected %0b, got %0b",
                                 $time, expected.hit, i_out_data.hit);
                        error_count++;
                    end
                    if (i_out_data.found_value !== expected.found_value) begin
                        $display("%0t: found_value expected %0d, got %0d",
                                 $time, expected.found_value, i_out_data.found_value);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_word(i_in_data, expected);
                awaited_answers.push_back(expected);
            end
        end
        o_errors   <= error_count;
        o_awaiting <= awaited_answers.size();
    end

endmodule

/* sim/hashed_result_cache_test.sv */
// Testbench top for the result cache: clock, reset, word stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module hashed_result_cache_test;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_WORDS = 1800;
    localparam int         LONG_HOLD    = 300;
    localparam int         IDLE_LIMIT   = 4 * (hrc_pkg::ENTRIES_DEFAULT + LONG_HOLD + 100);
    localparam logic [hrc_pkg::KEY_W-1:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [hrc_pkg::KEY_W-1:0] KEY_TOP  = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [hrc_pkg::KEY_W-1:0] key;
        logic [hrc_pkg::TAG_W-1:0] tag;
    } t_key_tag;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    hrc_pkg::t_in_word  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    hrc_pkg::t_out_word o_out_data;

    int        errors;
    int        awaiting;
    int        words_sent  = 0;
    int        idle_cycles = 0;
    t_key_tag  stored_pairs [$];

    hashed_result_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    hashed_result_cache_checker answer_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_awaiting  (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic hrc_pkg::t_in_word cache_word(input logic [1:0] cmd,
                                                     input logic [hrc_pkg::KEY_W-1:0] key,
                                                     input logic [hrc_pkg::TAG_W-1:0] tag,
                                                     input logic signed [hrc_pkg::VALUE_W-1:0] value);
        hrc_pkg::t_in_word w;
        w.cmd         = cmd;
        w.lookup_key  = key;
        w.tag_word    = tag;
        w.store_value = value;
        return w;
    endfunction

    function automatic logic [hrc_pkg::KEY_W-1:0] random_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return KEY_ONES;
            2:       return KEY_TOP >> $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [hrc_pkg::TAG_W-1:0] random_tag();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return hrc_pkg::TAG_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [hrc_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return hrc_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // Pairs that were stored are reused, often the latest ones so that a probe follows its
    // store closely. Flipping a high key bit or a high tag bit keeps the slot but spoils the match.
    task automatic pick_pair(output logic [hrc_pkg::KEY_W-1:0] key,
                             output logic [hrc_pkg::TAG_W-1:0] tag);
        int choice;
        int idx;
        choice = $urandom_range(0, 9);
        if (stored_pairs.size() == 0 || choice >= 8) begin
            key = random_key();
            tag = random_tag();
        end else begin
            if ($urandom_range(0, 1) == 0)
                idx = stored_pairs.size() - 1
                      - $urandom_range(0, (stored_pairs.size() > 4) ? 3 : stored_pairs.size() - 1);
            else
                idx = $urandom_range(0, stored_pairs.size() - 1);
            key = stored_pairs[idx].key;
            tag = stored_pairs[idx].tag;
            if (choice >= 5) begin
                if ($urandom_range(0, 1) == 0)
                    key = key ^ (KEY_TOP >> $urandom_range(0, 12));
                else
                    tag = tag ^ (16'h0800 << $urandom_range(0, 4));
            end
        end
    endtask

    task automatic next_random_word(output hrc_pkg::t_in_word w);
        int pick;
        t_key_tag pair;
        pick = $urandom_range(0, 99);
        pick_pair(pair.key, pair.tag);
        w = cache_word(hrc_pkg::CMD_PROBE, pair.key, pair.tag, random_value());
        if (pick < 1) begin
            w.cmd = hrc_pkg::CMD_CLEAR;
        end else if (pick < 4) begin
            w.cmd = CMD_UNUSED;
        end else if (pick < 44) begin
            w.cmd = hrc_pkg::CMD_STORE;
            stored_pairs.push_back(pair);
            if (stored_pairs.size() > 64) void'(stored_pairs.pop_front());
        end
    endtask

    task automatic send_word(input hrc_pkg::t_in_word w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        words_sent++;
    endtask

    initial begin : stimulus
        hrc_pkg::t_in_word w;
        int       burst;
        int       gap;
        int       random_left;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(cache_word(hrc_pkg::CMD_PROBE, '0, '0, '0));
        send_word(cache_word(hrc_pkg::CMD_STORE, '0, '0, 16'sh7FFF));
        send_word(cache_word(hrc_pkg::CMD_PROBE, '0, '0, '0));
        send_word(cache_word(hrc_pkg::CMD_STORE, KEY_ONES, 16'hFFFF, 16'sh8000));
        send_word(cache_word(hrc_pkg::CMD_PROBE, KEY_ONES, 16'hFFFF, 16'sh7FFF));
        send_word(cache_word(hrc_pkg::CMD_PROBE, KEY_ONES, 16'h7FFF, '0));
        send_word(cache_word(hrc_pkg::CMD_PROBE, KEY_ONES ^ KEY_TOP, 16'hFFFF, '0));
        send_word(cache_word(CMD_UNUSED, '0, '0, 16'sh0005));
        send_word(cache_word(hrc_pkg::CMD_PROBE, '0, '0, -16'sd1));
        send_word(cache_word(hrc_pkg::CMD_STORE, KEY_TOP, '0, -16'sd1));
        send_word(cache_word(hrc_pkg::CMD_PROBE, '0, '0, '0));
        send_word(cache_word(hrc_pkg::CMD_PROBE, KEY_TOP, '0, '0));
        send_word(cache_word(hrc_pkg::CMD_CLEAR, KEY_ONES, 16'hFFFF, 16'sh7FFF));
        send_word(cache_word(hrc_pkg::CMD_PROBE, KEY_ONES, 16'hFFFF, '0));
        send_word(cache_word(hrc_pkg::CMD_PROBE, KEY_TOP, '0, '0));
        send_word(cache_word(hrc_pkg::CMD_STORE, 64'hA5A5_5A5A_0F0F_F0F0, 16'h1234, '0));
        send_word(cache_word(hrc_pkg::CMD_PROBE, 64'hA5A5_5A5A_0F0F_F0F0, 16'h1234, 16'sh8000));
        send_word(cache_word(hrc_pkg::CMD_STORE, 64'hA5A5_5A5A_0F0F_F0F0, 16'h1234, 16'sd1));
        send_word(cache_word(hrc_pkg::CMD_PROBE, 64'hA5A5_5A5A_0F0F_F0F0, 16'h1234, '0));
        send_word(cache_word(hrc_pkg::CMD_PROBE, 64'h5A5A_A5A5_F0F0_0F0F, 16'hEDCB, '0));

        random_left = RANDOM_WORDS;
        while (random_left > 0) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                next_random_word(w);
                send_word(w);
                random_left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && awaiting == 0) begin
            $display("hashed_result_cache_test OK");
        end else begin
            $display("hashed_result_cache_test NOT OK");
        end
        $finish;
    end

    // Once the sender is well under way the receiver refuses every word for a long stretch,
    // so the cache fills up and has to hold off its input.
    initial begin : receiver
        int  run;
        int  mode;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && words_sent >= 500) begin
                held = 1'b1;
                repeat (LONG_HOLD) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            run  = $urandom_range(4, 40);
            mode = $urandom_range(0, 3);
            repeat (run) begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("hashed_result_cache_test NOT OK");
            $finish;
        end
    end

endmodule
